>>> sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_RULE(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on the edge that follows a reset cycle
`define ASSERT_AFTER_RESET(label, cond, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cond)) else $error(msg);

`endif

>>> sv/lbce_pkg.sv
`default_nettype none

package lbce_pkg;

  localparam int CODE_WIDTH   = 16;
  localparam int VALUE_W      = 16;
  localparam int BRIGHT_W     = 9;
  localparam int CHAN_W       = 8;
  localparam int BITS_PER_ROW = 3 * CHAN_W;
  localparam int CNT_W        = $clog2(BITS_PER_ROW);
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [VALUE_W-1:0] CODE_MASK =
    (CODE_WIDTH >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((64'd1 << CODE_WIDTH) - 64'd1);
  localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = BRIGHT_W'(256);
  localparam logic [CNT_W-1:0]    LAST_BIT    = CNT_W'(BITS_PER_ROW - 1);

  typedef enum logic [1:0] {
    ACT_LIT   = 2'd0,
    ACT_DARK  = 2'd1,
    ACT_RESET = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_ZERO_CODE  = 2'd0,
    REG_ONE_CODE   = 2'd1,
    REG_BRIGHTNESS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ROW_LIT,
    ROW_DARK,
    ROW_BLANK
  } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [BITS_PER_ROW-1:0]   word;
  } row_t;

  typedef struct packed {
    logic [VALUE_W-1:0] zero_code;
    logic [VALUE_W-1:0] one_code;
  } codes_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic finishing;
  } back_stat_t;

endpackage

`default_nettype wire

>>> sv/lbce_if.sv
`default_nettype none

interface lbce_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, action, red, green, blue, input ready);
  modport sink   (input valid, action, red, green, blue, output ready);
endinterface

interface lbce_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] compare_value;
  logic        last_of_run;
  modport source (output valid, compare_value, last_of_run, input ready);
  modport sink   (input valid, compare_value, last_of_run, output ready);
endinterface

interface lbce_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/lbce_front.sv
`default_nettype none

module lbce_front (
  lbce_in_if.sink                       in_ch,
  input  logic [lbce_pkg::BRIGHT_W-1:0] brightness,
  input  lbce_pkg::q_stat_t             q_stat,
  output logic                          push,
  output lbce_pkg::row_t                push_row
);
  import lbce_pkg::*;

  logic [CHAN_W+BRIGHT_W-1:0] prod_g;
  logic [CHAN_W+BRIGHT_W-1:0] prod_r;
  logic [CHAN_W+BRIGHT_W-1:0] prod_b;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  // truncating q1.8 scale, brightness never exceeds full so the result fits 8 bits
  assign prod_g = {{BRIGHT_W{1'b0}}, in_ch.green} * {{CHAN_W{1'b0}}, brightness};
  assign prod_r = {{BRIGHT_W{1'b0}}, in_ch.red}   * {{CHAN_W{1'b0}}, brightness};
  assign prod_b = {{BRIGHT_W{1'b0}}, in_ch.blue}  * {{CHAN_W{1'b0}}, brightness};

  always_comb begin
    push_row.word = '0;
    unique case (in_ch.action)
      ACT_LIT: begin
        push_row.kind = ROW_LIT;
        push_row.word = {prod_g[2*CHAN_W-1:CHAN_W], prod_r[2*CHAN_W-1:CHAN_W],
                         prod_b[2*CHAN_W-1:CHAN_W]};
      end
      ACT_DARK: push_row.kind = ROW_DARK;
      default:  push_row.kind = ROW_BLANK;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/lbce_fifo.sv
`default_nettype none

module lbce_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lbce_pkg::row_t    push_row,
  input  logic              pop,
  output lbce_pkg::row_t    head_row,
  output lbce_pkg::q_stat_t q_stat
);
  import lbce_pkg::*;

  row_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign head_row     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.valid = (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_row;
    end
  end

endmodule

`default_nettype wire

>>> sv/lbce_back.sv
`default_nettype none

module lbce_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lbce_pkg::codes_t     codes,
  input  lbce_pkg::q_stat_t    q_stat,
  input  lbce_pkg::row_t       head_row,
  output logic                 pop,
  output lbce_pkg::back_stat_t back_stat,
  lbce_out_if.source           out_ch
);
  import lbce_pkg::*;

  logic                    busy_r, busy_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  row_kind_t               kind_r, kind_nxt;
  logic [BITS_PER_ROW-1:0] word_r, word_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]      value_r, value_nxt;
  logic                    last_r, last_nxt;
  logic                    advance;
  logic                    at_last;
  logic [VALUE_W-1:0]      slot_value;

  assign advance = busy_r && (!out_valid_r || out_ch.ready);
  assign at_last = (cnt_r == LAST_BIT);
  // the next row loads on the cycle the current one sends its last slot
  assign pop     = q_stat.valid && (!busy_r || (advance && at_last));

  assign back_stat.busy      = busy_r;
  assign back_stat.finishing = advance && at_last;

  always_comb begin
    unique case (kind_r)
      ROW_LIT:  slot_value = word_r[BITS_PER_ROW-1] ? codes.one_code : codes.zero_code;
      ROW_DARK: slot_value = codes.zero_code;
      default:  slot_value = '0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    kind_nxt = kind_r;
    word_nxt = word_r;
    if (pop) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      kind_nxt = head_row.kind;
      word_nxt = head_row.word;
    end else if (advance) begin
      word_nxt = {word_r[BITS_PER_ROW-2:0], 1'b0};
      cnt_nxt  = cnt_r + 1'b1;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    value_nxt     = value_r;
    last_nxt      = last_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      value_nxt     = slot_value;
      last_nxt      = at_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    word_r  <= word_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.compare_value = value_r;
  assign out_ch.last_of_run   = last_r;

endmodule

`default_nettype wire

>>> sv/led_bit_code_encoder.sv
// led bit-code encoder: turns one row request into 24 timer compare values
// in_ch: row requests (action, red, green, blue), taken when valid and ready
//   action lit scales each channel by brightness, dark sends 24 zero codes,
//   reset row (and the unused code) sends 24 zeros
// out_ch: one compare value per transfer, green red blue msb first,
//   last_of_run set on the 24th value of each row
// cfg_ch: index 0 zero code, 1 one code, 2 brightness (q1.8, above 256 is
//   held at 256), other indexes dropped; ready is always high, write only
//   while no row is in flight
// a row's first value goes through the row queue, the serializer and the output register
// throughput: one value per cycle from the bit serializer while out_ch is ready;
//   a two-entry row queue lets requests arrive while a row is being sent
// a stalled receiver holds the output register and the serializer, then the
//   queue fills and in_ch.ready drops
// reset: codes go to 0, brightness to full, queue and serializer empty
`default_nettype none

module led_bit_code_encoder (
  input  logic       clk,
  input  logic       rst_n,
  lbce_in_if.sink    in_ch,
  lbce_out_if.source out_ch,
  lbce_cfg_if.sink   cfg_ch
);
  import lbce_pkg::*;
  `include "assert_macros.svh"

  logic [VALUE_W-1:0]  zero_code_r, zero_code_nxt;
  logic [VALUE_W-1:0]  one_code_r, one_code_nxt;
  logic [BRIGHT_W-1:0] bright_r, bright_nxt;
  logic [BRIGHT_W-1:0] bright_wr;
  logic                cfg_fire;

  logic       push;
  row_t       push_row;
  row_t       head_row;
  logic       pop;
  q_stat_t    q_stat;
  back_stat_t back_stat;
  codes_t     codes;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign bright_wr    = cfg_ch.data[BRIGHT_W-1:0];

  always_comb begin
    zero_code_nxt = zero_code_r;
    one_code_nxt  = one_code_r;
    bright_nxt    = bright_r;
    if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_ZERO_CODE:  zero_code_nxt = cfg_ch.data & CODE_MASK;
        REG_ONE_CODE:   one_code_nxt  = cfg_ch.data & CODE_MASK;
        REG_BRIGHTNESS: bright_nxt    = (bright_wr > BRIGHT_FULL) ? BRIGHT_FULL : bright_wr;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_code_r <= '0;
      one_code_r  <= '0;
      bright_r    <= BRIGHT_FULL;
    end else begin
      zero_code_r <= zero_code_nxt;
      one_code_r  <= one_code_nxt;
      bright_r    <= bright_nxt;
    end
  end

  assign codes.zero_code = zero_code_r;
  assign codes.one_code  = one_code_r;

  lbce_front u_front (
    .in_ch      (in_ch),
    .brightness (bright_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_row   (push_row)
  );

  lbce_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_row (push_row),
    .pop      (pop),
    .head_row (head_row),
    .q_stat   (q_stat)
  );

  lbce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .codes     (codes),
    .q_stat    (q_stat),
    .head_row  (head_row),
    .pop       (pop),
    .back_stat (back_stat),
    .out_ch    (out_ch)
  );

  `ASSERT_RULE(a_push_room, push |-> !q_stat.full, "row pushed into a full queue")
  `ASSERT_RULE(a_pop_data, pop |-> q_stat.valid, "row popped from an empty queue")
  `ASSERT_RULE(a_pop_slot, pop |-> (!back_stat.busy || back_stat.finishing), "row loaded mid-run")
  `ASSERT_AFTER_RESET(a_reset_out, !out_ch.valid, "output valid right after reset")

endmodule

`default_nettype wire

>>> tb/lbce_checker.sv
`default_nettype none

module lbce_checker (
  input  logic  clk,
  input  logic  rst_n,
  lbce_in_if    in_mon,
  lbce_out_if   out_mon,
  lbce_cfg_if   cfg_mon,
  output int    fails,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import lbce_pkg::*;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
  } slot_t;

  slot_t slots_q[$];

  logic [VALUE_W-1:0]  zero_code = '0;
  logic [VALUE_W-1:0]  one_code = '0;
  logic [BRIGHT_W-1:0] bright = BRIGHT_FULL;
  int                  fail_cnt = 0;

  // truncating product with a q1.8 brightness
  function automatic logic [CHAN_W-1:0] dim(input logic [CHAN_W-1:0] chan,
                                            input logic [BRIGHT_W-1:0] br);
    logic [CHAN_W+BRIGHT_W-1:0] prod;
    prod = chan * br;
    return prod[CHAN_W+7:8];
  endfunction

  task automatic queue_row(input logic [1:0] act, input logic [CHAN_W-1:0] r,
                           input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
    logic [BITS_PER_ROW-1:0] word;
    slot_t                   s;
    word = {dim(g, bright), dim(r, bright), dim(b, bright)};
    for (int k = 0; k < BITS_PER_ROW; k++) begin
      case (act)
        ACT_LIT:  s.value = word[BITS_PER_ROW-1-k] ? one_code : zero_code;
        ACT_DARK: s.value = zero_code;
        default:  s.value = '0;
      endcase
      s.last = (k == BITS_PER_ROW - 1);
      slots_q.push_back(s);
    end
  endtask

  always @(posedge clk) begin : watch
    slot_t               want;
    logic [BRIGHT_W-1:0] b;
    if (!rst_n) begin
      slots_q.delete();
      zero_code = '0;
      one_code = '0;
      bright = BRIGHT_FULL;
      fail_cnt = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_ZERO_CODE: zero_code = cfg_mon.data & CODE_MASK;
          REG_ONE_CODE:  one_code = cfg_mon.data & CODE_MASK;
          REG_BRIGHTNESS: begin
            b = cfg_mon.data[BRIGHT_W-1:0];
            bright = (b > BRIGHT_FULL) ? BRIGHT_FULL : b;
          end
          default: ;
        endcase
      end
      // results are checked before a row taken on the same edge is queued
      if (out_mon.valid && out_mon.ready) begin
        if (slots_q.size() == 0) begin
          $error("compare_value: no row pending, got %h (last_of_run %b)",
                 out_mon.compare_value, out_mon.last_of_run);
          fail_cnt++;
        end else begin
          want = slots_q.pop_front();
          if (out_mon.compare_value !== want.value) begin
            $error("compare_value: expected %h, got %h", want.value, out_mon.compare_value);
            fail_cnt++;
          end
          if (out_mon.last_of_run !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, out_mon.last_of_run);
            fail_cnt++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        queue_row(in_mon.action, in_mon.red, in_mon.green, in_mon.blue);
    end
    fails <= fail_cnt;
    outstanding <= slots_q.size();
  end

endmodule

`default_nettype wire

>>> tb/led_bit_code_encoder_tb.sv
`default_nettype none

module led_bit_code_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbce_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         DRAIN_CYCLES = 4;

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;
  int   stall_left = 0;
  bit   src_calm = 1'b0;
  bit   sink_calm = 1'b0;
  int   fails;
  int   outstanding;

  lbce_in_if  in_ch ();
  lbce_out_if out_ch ();
  lbce_cfg_if cfg_ch ();

  assign out_ch.ready = sink_ready;

  always #4 clk = ~clk;

  led_bit_code_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lbce_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fails       (fails),
    .outstanding (outstanding)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [1:0] rand_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return ACT_LIT;
    if (r < 80) return ACT_DARK;
    if (r < 90) return ACT_RESET;
    return ACT_UNUSED;
  endfunction

  function automatic logic [15:0] rand_code();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] rand_bright();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd128;
      3:       return 16'd255;
      4:       return 16'd256;
      5:       return 16'($urandom_range(257, 511));
      6:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 256));
    endcase
  endfunction

  // receiver stalls
  always @(posedge clk) begin : sink_drive
    int g;
    if (!rst_n) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_calm) begin
      sink_ready <= 1'b1;
    end else begin
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      sink_ready <= (g == 0);
      stall_left <= (g > 0) ? g - 1 : 0;
    end
  end

  task automatic send_row(input logic [1:0] act, input logic [7:0] r,
                          input logic [7:0] g, input logic [7:0] b);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.red <= r;
    in_ch.green <= g;
    in_ch.blue <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (!src_calm) idle_src(gap_len());
  endtask

  task automatic idle_src(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the sender until every queued compare value has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] zc, input logic [15:0] oc,
                          input logic [15:0] br);
    drain();
    write_reg(REG_ZERO_CODE, zc);
    write_reg(REG_ONE_CODE, oc);
    write_reg(REG_BRIGHTNESS, br);
  endtask

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_LIT;
    in_ch.red <= '0;
    in_ch.green <= '0;
    in_ch.blue <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_ZERO_CODE;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // codes still at their reset values
    send_row(ACT_LIT, 8'hFF, 8'hFF, 8'hFF);

    set_regs(16'h0000, 16'hFFFF, 16'd256);
    send_row(ACT_LIT, 8'hFF, 8'hFF, 8'hFF);
    send_row(ACT_LIT, 8'h00, 8'h00, 8'h00);
    send_row(ACT_LIT, 8'h80, 8'h01, 8'hAA);
    send_row(ACT_DARK, 8'hFF, 8'hFF, 8'hFF);
    send_row(ACT_RESET, 8'hFF, 8'hFF, 8'hFF);
    send_row(ACT_UNUSED, 8'h5A, 8'hA5, 8'h3C);

    set_regs(16'hFFFF, 16'h0000, 16'd0);
    send_row(ACT_LIT, 8'hFF, 8'hFF, 8'hFF);
    send_row(ACT_DARK, 8'h00, 8'h00, 8'h00);

    // brightness above full saturates; then brightness 1, 255 and 128
    set_regs(16'h5A5A, 16'hA5A5, 16'h01FF);
    send_row(ACT_LIT, 8'h12, 8'h34, 8'h56);
    drain();
    write_reg(REG_BRIGHTNESS, 16'hFFFF);
    send_row(ACT_LIT, 8'hFF, 8'h80, 8'h01);
    drain();
    write_reg(REG_BRIGHTNESS, 16'd257);
    send_row(ACT_LIT, 8'hFF, 8'hFF, 8'hFF);
    drain();
    write_reg(REG_BRIGHTNESS, 16'd1);
    send_row(ACT_LIT, 8'hFF, 8'hFF, 8'hFF);
    drain();
    write_reg(REG_BRIGHTNESS, 16'd255);
    send_row(ACT_LIT, 8'hFF, 8'h01, 8'h80);
    drain();
    write_reg(REG_BRIGHTNESS, 16'd128);
    send_row(ACT_LIT, 8'hFF, 8'hFE, 8'h03);
    // unknown index leaves every register alone
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_row(ACT_LIT, 8'hC3, 8'h3C, 8'h99);
    send_row(ACT_DARK, 8'h00, 8'hFF, 8'h00);

    for (int p = 0; p < 6; p++) begin
      set_regs(rand_code(), rand_code(), rand_bright());
      if (p == 3) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      src_calm = (p == 2);
      sink_calm = (p == 2);
      for (int i = 0; i < 14; i++) begin
        if (p == 1 && i == 9) drain();
        send_row(rand_action(), rand_chan(), rand_chan(), rand_chan());
      end
    end
    src_calm = 1'b0;
    sink_calm = 1'b0;

    drain();
    repeat (30) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
